/* rtl/flvd_pkg.sv */
// ----------------------------------------------------------------------------
// flvd_pkg
// Types and constants shared by the FLV tag deframer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package flvd_pkg;

    localparam logic [3:0]  FILE_HDR_BYTES  = 4'd13;
    localparam logic [3:0]  TAG_HDR_LAST    = 4'd10;   // index of the final tag header byte
    localparam logic [3:0]  TRAILER_LAST    = 4'd3;    // index of the final trailer byte
    localparam logic [31:0] TAG_HDR_SIZE    = 32'd11;
    localparam logic [23:0] MAX_LEN_DEFAULT = 24'd10485760;

    localparam logic [1:0] KIND_BODY     = 2'd0;
    localparam logic [1:0] KIND_DONE     = 2'd1;
    localparam logic [1:0] KIND_LEN_ERR  = 2'd2;
    localparam logic [1:0] KIND_TYPE_ERR = 2'd3;

    localparam logic [7:0] TYPE_AUDIO  = 8'd8;
    localparam logic [7:0] TYPE_VIDEO  = 8'd9;
    localparam logic [7:0] TYPE_SCRIPT = 8'd18;

    typedef enum logic [2:0] {
        PH_FILE    = 3'd0,
        PH_TAGHDR  = 3'd1,
        PH_BODY    = 3'd2,
        PH_TRAILER = 3'd3,
        PH_HALT    = 3'd4
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  body_byte;
        logic [7:0]  tag_type;
        logic [31:0] timestamp;
        logic [23:0] tag_length;
        logic        first_of_body;
        logic        last_of_body;
        logic        size_mismatch;
    } t_result;

endpackage

/* rtl/flvd_parse.sv */
// ----------------------------------------------------------------------------
// flvd_parse
// Stream state machine: walks file header, tag header, body and trailer,
// one byte per advance, and produces at most one result per byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flvd_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [23:0]       i_max_len,
    input  logic              i_adv,
    input  logic [7:0]        i_byte,
    output logic              o_push,
    output flvd_pkg::t_result o_res
);
    import flvd_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [3:0]  r_hdr_left, n_hdr_left;
    logic [3:0]  r_fidx,   n_fidx;
    logic [23:0] r_bcnt,   n_bcnt;
    logic [7:0]  r_type,   n_type;
    logic [31:0] r_time,   n_time;
    logic [23:0] r_len,    n_len;
    logic [31:0] r_trail,  n_trail;

    logic [3:0]  hdr_dec;
    logic [24:0] bcnt_inc;
    logic        known;
    logic        mismatch;

    always_comb begin
        n_phase    = r_phase;
        n_hdr_left = r_hdr_left;
        n_fidx     = r_fidx;
        n_bcnt     = r_bcnt;
        n_type     = r_type;
        n_time     = r_time;
        n_len      = r_len;
        n_trail    = r_trail;
        o_push     = 1'b0;
        o_res      = '0;

        hdr_dec  = (r_hdr_left != 4'd0) ? r_hdr_left - 4'd1 : 4'd0;
        bcnt_inc = {1'b0, r_bcnt} + 25'd1;
        n_trail  = r_trail;
        known    = (r_type == TYPE_AUDIO) || (r_type == TYPE_VIDEO)
                   || (r_type == TYPE_SCRIPT);
        mismatch = ({r_trail[23:0], i_byte} != ({8'd0, r_len} + TAG_HDR_SIZE));

        if (i_adv) begin
            unique case (r_phase)
                PH_FILE: begin
                    n_hdr_left = hdr_dec;
                    if (hdr_dec == 4'd0) begin
                        n_phase = PH_TAGHDR;
                        n_fidx  = 4'd0;
                    end
                end
                PH_TAGHDR: begin
                    case (r_fidx)
                        4'd0: begin
                            n_type = i_byte;
                            n_len  = '0;
                            n_time = '0;
                        end
                        4'd1:    n_len[23:16]  = i_byte;
                        4'd2:    n_len[15:8]   = i_byte;
                        4'd3:    n_len[7:0]    = i_byte;
                        4'd4:    n_time[23:16] = i_byte;
                        4'd5:    n_time[15:8]  = i_byte;
                        4'd6:    n_time[7:0]   = i_byte;
                        4'd7:    n_time[31:24] = i_byte;
                        default: ;   // stream id, ignored
                    endcase
                    n_fidx = r_fidx + 4'd1;
                    if (r_fidx >= TAG_HDR_LAST) begin
                        n_fidx  = 4'd0;
                        n_bcnt  = '0;
                        n_trail = '0;
                        if (n_len > i_max_len) begin
                            n_phase          = PH_HALT;
                            o_push           = 1'b1;
                            o_res.kind       = KIND_LEN_ERR;
                            o_res.tag_type   = n_type;
                            o_res.timestamp  = n_time;
                            o_res.tag_length = n_len;
                        end else begin
                            n_phase = (n_len == 24'd0) ? PH_TRAILER : PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    n_bcnt              = bcnt_inc[23:0];
                    o_push              = 1'b1;
                    o_res.kind          = KIND_BODY;
                    o_res.body_byte     = i_byte;
                    o_res.tag_type      = r_type;
                    o_res.timestamp     = r_time;
                    o_res.tag_length    = r_len;
                    o_res.first_of_body = (r_bcnt == 24'd0);
                    o_res.last_of_body  = (bcnt_inc >= {1'b0, r_len});
                    if (bcnt_inc >= {1'b0, r_len}) begin
                        n_phase = PH_TRAILER;
                        n_fidx  = 4'd0;
                        n_trail = '0;
                    end
                end
                PH_TRAILER: begin
                    n_trail = {r_trail[23:0], i_byte};
                    n_fidx  = r_fidx + 4'd1;
                    if (r_fidx >= TRAILER_LAST) begin
                        n_fidx              = 4'd0;
                        n_phase             = known ? PH_TAGHDR : PH_HALT;
                        o_push              = 1'b1;
                        o_res.kind          = known ? KIND_DONE : KIND_TYPE_ERR;
                        o_res.tag_type      = r_type;
                        o_res.timestamp     = r_time;
                        o_res.tag_length    = r_len;
                        o_res.size_mismatch = mismatch;
                    end
                end
                default: ;   // halted: bytes are dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FILE;
            r_hdr_left <= FILE_HDR_BYTES;
            r_fidx     <= '0;
            r_bcnt     <= '0;
            r_type     <= '0;
            r_time     <= '0;
            r_len      <= '0;
            r_trail    <= '0;
        end else begin
            r_phase    <= n_phase;
            r_hdr_left <= n_hdr_left;
            r_fidx     <= n_fidx;
            r_bcnt     <= n_bcnt;
            r_type     <= n_type;
            r_time     <= n_time;
            r_len      <= n_len;
            r_trail    <= n_trail;
        end
    end

endmodule

/* rtl/flvd_outq.sv */
// ----------------------------------------------------------------------------
// flvd_outq
// Output register plus skid entry: holds up to two results so the parser
// keeps going while the downstream side stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flvd_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  flvd_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_valid,
    output flvd_pkg::t_result o_res,
    output logic              o_full
);
    import flvd_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    take;

    assign take = r_out_valid && !i_stall;

    // push never arrives while the skid entry is occupied
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_out = i_res;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                n_out       = i_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_res;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_full  = r_skid_valid;

endmodule

/* rtl/flv_tag_deframer.sv */
// ----------------------------------------------------------------------------
// flv_tag_deframer
// Byte-serial FLV deframer: tag header capture, body pass-through, trailer check.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock while o_stall is low. A byte lands in an
// input register, the parser updates its state from it once the output queue
// has room, and any result goes on to the output queue.
// Results queue in the output register and one skid entry; o_stall rises only
// when both are full and a byte is still waiting in the input register, so a
// stalled consumer slows the stream only once two results are pending.
// After a length or type error all bytes are dropped until reset. The
// length limit is written through i_cfg_we/i_cfg_data; the user must do so
// only while the stream is idle, as the block itself does not enforce it.
`timescale 1ns / 1ps

module flv_tag_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_stream_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_body_byte,
    output logic [7:0]  o_tag_type,
    output logic [31:0] o_timestamp,
    output logic [23:0] o_tag_length,
    output logic        o_first_of_body,
    output logic        o_last_of_body,
    output logic        o_size_mismatch
);
    import flvd_pkg::*;

    logic [23:0] r_max_len;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        adv;
    logic        accept;
    logic        push;
    logic        q_full;
    t_result     res;
    t_result     out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_DEFAULT;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

    assign o_stall = r_in_valid && q_full;
    assign accept  = i_valid && !o_stall;
    assign adv     = r_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
        if (accept) begin
            r_in_byte <= i_stream_byte;
        end
    end

    flvd_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_max_len (r_max_len),
        .i_adv     (adv),
        .i_byte    (r_in_byte),
        .o_push    (push),
        .o_res     (res)
    );

    flvd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (out_res),
        .o_full  (q_full)
    );

    assign o_kind          = out_res.kind;
    assign o_body_byte     = out_res.body_byte;
    assign o_tag_type      = out_res.tag_type;
    assign o_timestamp     = out_res.timestamp;
    assign o_tag_length    = out_res.tag_length;
    assign o_first_of_body = out_res.first_of_body;
    assign o_last_of_body  = out_res.last_of_body;
    assign o_size_mismatch = out_res.size_mismatch;

endmodule

/* rtl/flvd_checker.sv */
// ----------------------------------------------------------------------------
// flvd_checker
// Port-level checks for the FLV tag deframer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flvd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_body_byte,
    input logic [23:0] o_tag_length,
    input logic        o_first_of_body,
    input logic        o_last_of_body,
    input logic        o_size_mismatch
);
    import flvd_pkg::*;

    // a stalled result stays valid with its kind and body byte unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_body_byte))
        else $error("stalled result changed");

    a_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != KIND_BODY) |->
            (o_body_byte == 8'd0) && !o_first_of_body && !o_last_of_body)
        else $error("body fields set on a non-body result");

    a_mismatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_kind == KIND_BODY) || (o_kind == KIND_LEN_ERR)) |->
            !o_size_mismatch)
        else $error("size mismatch outside tag end");

    // a length error needs a length above some limit, so never zero
    a_len_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_LEN_ERR) |-> (o_tag_length != 24'd0))
        else $error("length error with zero length");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result present right after reset");

endmodule

bind flv_tag_deframer flvd_checker u_flvd_checker (.*);
